// ===== rtl/core/trq_pkg.sv =====
// shared types and codes for the thread ready queue scheduler
// no dependencies; used by trq_cell, trq_chain and the top level

package trq_pkg;

  // default number of thread identifiers
  localparam int MaxThreads = 32;

  // fixed widths of the item fields
  localparam int CmdW  = 2;
  localparam int KindW = 2;
  localparam int TidW  = 6;
  localparam int StatW = 2;
  localparam int ResW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE = 2'd0,
    CMD_YIELD  = 2'd1,
    CMD_EXIT   = 2'd2
  } trq_cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_SPECIFIC = 2'd0,
    KIND_ANY      = 2'd1,
    KIND_SELF     = 2'd2
  } trq_kind_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_NOMORE  = 2'd1,
    ST_NONE    = 2'd2,
    ST_INVALID = 2'd3
  } trq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } trq_state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic capture;    // latch id compare result
    logic shift;      // close the gap from the removed slot onward
    logic use_match;  // removed slot found by compare, else by position
    logic tail_wr;    // write tail value at tail slot
    logic head_wr;    // write head value into slot 0
  } trq_ctrl_t;

endpackage

// ===== rtl/core/trq_cell.sv =====
// one queue slot: holds an identifier and its compare flag
// depends on trq_pkg

module trq_cell #(
  parameter int IdW    = 5,
  parameter bit IsHead = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trq_pkg::trq_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  logic               pos_hit_i,
  input  logic               tail_hit_i,
  input  logic               from_i,
  input  logic [IdW-1:0]     next_id_i,
  input  logic [IdW-1:0]     cmp_id_i,
  input  logic [IdW-1:0]     tail_val_i,
  input  logic [IdW-1:0]     head_val_i,
  output logic [IdW-1:0]     id_o,
  output logic               match_o,
  output logic               from_o
);

  logic [IdW-1:0] id_q, id_d;
  logic           match_q, match_d;
  logic           hit;

  // this slot or an earlier one is removed
  assign hit    = ctrl_i.use_match ? match_q : pos_hit_i;
  assign from_o = from_i | hit;

  // next slot contents
  always_comb begin
    id_d    = id_q;
    match_d = match_q;
    if (ctrl_i.capture) begin
      match_d = valid_i && (id_q == cmp_id_i);
    end
    if (ctrl_i.shift && from_o) begin
      id_d = next_id_i;
    end
    if (ctrl_i.tail_wr && tail_hit_i) begin
      id_d = tail_val_i;
    end
    if (IsHead && ctrl_i.head_wr) begin
      id_d = head_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= '0;
      match_q <= 1'b0;
    end else begin
      id_q    <= id_d;
      match_q <= match_d;
    end
  end

  assign id_o    = id_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/trq_chain.sv =====
// row of queue cells, head in cell 0, each but the last shifting from its right neighbor
// depends on trq_pkg and trq_cell

module trq_chain #(
  parameter int MaxThreads = trq_pkg::MaxThreads
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trq_pkg::trq_ctrl_t                ctrl_i,
  input  logic [$clog2(MaxThreads+1)-1:0]   count_i,
  input  logic [$clog2(MaxThreads+1)-1:0]   tail_idx_i,
  input  logic                              rm_pos_i,
  input  logic [$clog2(MaxThreads)-1:0]     cmp_id_i,
  input  logic [$clog2(MaxThreads)-1:0]     tail_val_i,
  input  logic [$clog2(MaxThreads)-1:0]     head_val_i,
  output logic [$clog2(MaxThreads)-1:0]     head_id_o,
  output logic [$clog2(MaxThreads)-1:0]     second_id_o,
  output logic [MaxThreads-1:0]             match_o
);

  localparam int IdW  = $clog2(MaxThreads);
  localparam int CntW = $clog2(MaxThreads+1);

  logic [IdW-1:0]      ids [MaxThreads];
  logic [MaxThreads:0] from;

  assign from[0] = 1'b0;

  for (genvar i = 0; i < MaxThreads; i++) begin : g_cell
    logic           valid;
    logic           pos_hit;
    logic           tail_hit;
    logic [IdW-1:0] next_id;

    // per-slot position decode
    assign valid    = CntW'(i) < count_i;
    assign tail_hit = CntW'(i) == tail_idx_i;
    if (i == 0) begin : g_p0
      assign pos_hit = !rm_pos_i;
    end else if (i == 1) begin : g_p1
      assign pos_hit = rm_pos_i;
    end else begin : g_pn
      assign pos_hit = 1'b0;
    end

    // last cell has no neighbor; its value is past the tail after a shift
    if (i < MaxThreads - 1) begin : g_nb
      assign next_id = ids[i+1];
    end else begin : g_last
      assign next_id = ids[i];
    end

    trq_cell #(
      .IdW    (IdW),
      .IsHead (i == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .valid_i    (valid),
      .pos_hit_i  (pos_hit),
      .tail_hit_i (tail_hit),
      .from_i     (from[i]),
      .next_id_i  (next_id),
      .cmp_id_i   (cmp_id_i),
      .tail_val_i (tail_val_i),
      .head_val_i (head_val_i),
      .id_o       (ids[i]),
      .match_o    (match_o[i]),
      .from_o     (from[i+1])
    );
  end

  assign head_id_o   = ids[0];
  assign second_id_o = ids[1];

endmodule

// ===== rtl/core/thread_ready_queue_scheduler.sv =====
// top level of the thread ready queue scheduler: sequencer, alive map, results
// depends on trq_pkg and trq_chain
//
// Usage
//   A request item (command_i, target_kind_i, target_id_i) is taken at a
//   rising edge where start is high and busy is low. The queue lives in a row
//   of cells, head in cell 0; the head is the running thread.
//   Each item is worked in a compare phase, in which every cell compares its
//   identifier with target_id_i and the lowest free identifier is found in
//   the alive map, and then an apply phase, in which the cells shift to close
//   the gap and write the tail or head. The result (status_o, result_id_o,
//   running_id_o) is shown for exactly one cycle with done_o high, registered
//   from the apply phase; busy is high during the compare and apply phases,
//   and a new item may be started in the cycle in which done_o is high, so
//   an item is not taken before the previous one has left its apply phase.
//   The receiver cannot stall; results are never held back.
//   Reset (rst_ni low, asynchronous) leaves only thread 0 queued and alive,
//   running_id_o at 0, busy and done_o low.

module thread_ready_queue_scheduler #(
  parameter int MaxThreads = trq_pkg::MaxThreads
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [trq_pkg::CmdW-1:0]  command_i,
  input  logic [trq_pkg::KindW-1:0] target_kind_i,
  input  logic [trq_pkg::TidW-1:0]  target_id_i,
  output logic                     done_o,
  output logic [trq_pkg::StatW-1:0] status_o,
  output logic [trq_pkg::ResW-1:0]  result_id_o,
  output logic [trq_pkg::ResW-1:0]  running_id_o
);

  localparam int IdW  = $clog2(MaxThreads);
  localparam int CntW = $clog2(MaxThreads+1);

  trq_pkg::trq_state_e state_q, state_d;

  // latched request
  logic [trq_pkg::CmdW-1:0]  cmd_q;
  logic [trq_pkg::KindW-1:0] kind_q;
  logic [trq_pkg::TidW-1:0]  tid_q;

  logic [CntW-1:0]       count_q, count_d;
  logic [MaxThreads-1:0] alive_q, alive_d;

  logic [IdW-1:0] free_id, free_id_q;
  logic           free_ok, free_ok_q;

  trq_pkg::trq_status_e status_q, status_d;
  logic [trq_pkg::ResW-1:0] rid_q, rid_d;
  logic                     done_q, done_d;

  trq_pkg::trq_ctrl_t ctrl;
  logic [CntW-1:0]       tail_idx;
  logic                  rm_pos;
  logic [IdW-1:0]        tail_val, head_val, head_id, second_id, rid;
  logic [MaxThreads-1:0] match;
  logic                  tid_ok, found, head_hit, accept;
  trq_pkg::trq_status_e  status;

  assign accept = start && !busy;
  assign busy   = state_q != trq_pkg::S_IDLE;

  trq_chain #(
    .MaxThreads (MaxThreads)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .count_i     (count_q),
    .tail_idx_i  (tail_idx),
    .rm_pos_i    (rm_pos),
    .cmp_id_i    (tid_q[IdW-1:0]),
    .tail_val_i  (tail_val),
    .head_val_i  (head_val),
    .head_id_o   (head_id),
    .second_id_o (second_id),
    .match_o     (match)
  );

  // lowest free identifier
  always_comb begin
    free_ok = 1'b0;
    free_id = '0;
    for (int i = MaxThreads - 1; i >= 0; i--) begin
      if (!alive_q[i]) begin
        free_ok = 1'b1;
        free_id = IdW'(i);
      end
    end
  end

  // target lookup from the cell compare flags
  assign tid_ok   = int'(tid_q) < MaxThreads;
  assign found    = tid_ok && (|match);
  assign head_hit = tid_ok && match[0];

  // next state, cell control and result
  always_comb begin
    state_d  = state_q;
    ctrl     = '0;
    tail_idx = count_q;
    rm_pos   = 1'b0;
    tail_val = head_id;
    head_val = tid_q[IdW-1:0];
    count_d  = count_q;
    alive_d  = alive_q;
    status   = trq_pkg::ST_INVALID;
    rid      = '0;
    status_d = status_q;
    rid_d    = rid_q;
    done_d   = 1'b0;
    case (state_q)
      trq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = trq_pkg::S_MATCH;
        end
      end
      trq_pkg::S_MATCH: begin
        ctrl.capture = 1'b1;
        state_d      = trq_pkg::S_APPLY;
      end
      trq_pkg::S_APPLY: begin
        case (cmd_q)
          trq_pkg::CMD_CREATE: begin
            if (free_ok_q) begin
              ctrl.tail_wr       = 1'b1;
              tail_val           = free_id_q;
              count_d            = count_q + CntW'(1);
              alive_d[free_id_q] = 1'b1;
              status             = trq_pkg::ST_OK;
              rid                = free_id_q;
            end else begin
              status = trq_pkg::ST_NOMORE;
            end
          end
          trq_pkg::CMD_YIELD: begin
            case (kind_q)
              trq_pkg::KIND_ANY: begin
                if (count_q < CntW'(2)) begin
                  status = trq_pkg::ST_NONE;
                end else begin
                  // rotate head to tail
                  ctrl.shift   = 1'b1;
                  ctrl.tail_wr = 1'b1;
                  tail_idx     = count_q - CntW'(1);
                  status       = trq_pkg::ST_OK;
                  rid          = second_id;
                end
              end
              trq_pkg::KIND_SELF: begin
                status = trq_pkg::ST_OK;
                rid    = head_id;
              end
              trq_pkg::KIND_SPECIFIC: begin
                if (head_hit) begin
                  status = trq_pkg::ST_OK;
                  rid    = head_id;
                end else if (found) begin
                  // pull target out, old head to tail, target to head
                  ctrl.shift     = 1'b1;
                  ctrl.use_match = 1'b1;
                  ctrl.tail_wr   = 1'b1;
                  ctrl.head_wr   = 1'b1;
                  tail_idx       = count_q - CntW'(1);
                  status         = trq_pkg::ST_OK;
                  rid            = tid_q[IdW-1:0];
                end
              end
              default: begin
                status = trq_pkg::ST_INVALID;
              end
            endcase
          end
          trq_pkg::CMD_EXIT: begin
            if (kind_q == trq_pkg::KIND_ANY) begin
              if (count_q < CntW'(2)) begin
                status = trq_pkg::ST_NONE;
              end else begin
                ctrl.shift         = 1'b1;
                rm_pos             = 1'b1;
                count_d            = count_q - CntW'(1);
                alive_d[second_id] = 1'b0;
                status             = trq_pkg::ST_OK;
                rid                = second_id;
              end
            end else if (kind_q == trq_pkg::KIND_SELF ||
                         (kind_q == trq_pkg::KIND_SPECIFIC && head_hit)) begin
              if (count_q < CntW'(2)) begin
                status = trq_pkg::ST_NONE;
              end else begin
                ctrl.shift       = 1'b1;
                count_d          = count_q - CntW'(1);
                alive_d[head_id] = 1'b0;
                status           = trq_pkg::ST_OK;
                rid              = head_id;
              end
            end else if (kind_q == trq_pkg::KIND_SPECIFIC && found) begin
              ctrl.shift              = 1'b1;
              ctrl.use_match          = 1'b1;
              count_d                 = count_q - CntW'(1);
              alive_d[tid_q[IdW-1:0]] = 1'b0;
              status                  = trq_pkg::ST_OK;
              rid                     = tid_q[IdW-1:0];
            end
          end
          default: begin
            status = trq_pkg::ST_INVALID;
          end
        endcase
        status_d = status;
        rid_d    = trq_pkg::ResW'(rid);
        done_d   = 1'b1;
        state_d  = trq_pkg::S_IDLE;
      end
      default: begin
        state_d = trq_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trq_pkg::S_IDLE;
      count_q <= CntW'(1);
      alive_q <= MaxThreads'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      alive_q <= alive_d;
      done_q  <= done_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      kind_q <= target_kind_i;
      tid_q  <= target_id_i;
    end
    if (state_q == trq_pkg::S_MATCH) begin
      free_id_q <= free_id;
      free_ok_q <= free_ok;
    end
    status_q <= status_d;
    rid_q    <= rid_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign result_id_o  = rid_q;
  assign running_id_o = trq_pkg::ResW'(head_id);

  // checks
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trq_pkg::S_APPLY) |=> done_o)
    else $error("result strobe missing after apply");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (int'(count_q) <= MaxThreads))
    else $error("queue count out of range");

  a_alive_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(alive_q) == int'(count_q))
    else $error("alive map disagrees with queue count");

  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != trq_pkg::ST_OK) |-> (result_id_o == '0))
    else $error("nonzero result id on failed request");

  a_accept_to_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == trq_pkg::S_MATCH))
    else $error("accepted item did not enter compare phase");

endmodule
